// ===== rtl/flb_pkg.sv =====
// ----------------------------------------------------------------------------
// flb_pkg
// Shared types, widths and codes of the free-list buffer allocator.
// ----------------------------------------------------------------------------
package flb_pkg;

	// Stack depth: the number of offsets the free stack can hold.
	localparam int POOL_DEPTH = 1024;

	localparam int ADDR_W    = 26;
	localparam int SIZE_W    = 16;
	localparam int COUNT_W   = 11;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

	// Level after reset: the reset pool count, limited by the stack depth.
	localparam int RESET_POOL_COUNT   = 1024;
	localparam int RESET_ELEMENT_SIZE = 64;
	localparam int RESET_LEVEL        =
		(RESET_POOL_COUNT < POOL_DEPTH) ? RESET_POOL_COUNT : POOL_DEPTH;

	// Commands; only the upper bit selects initialize.
	localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INIT     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_INIT_ALT = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_FREED   = 3'd2,
		ST_FULL    = 3'd3,
		ST_NULL    = 3'd4,
		ST_INIT    = 3'd5
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT   = 1'd1;

endpackage

// ===== rtl/free_list_buffer_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_buffer_allocator
// LIFO pool of equal-sized buffers, kept as a stack of free byte offsets.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready): one item per command - allocate pops
//   the top offset, free pushes elem_offset, initialize reloads the pool.
//   rsp channel (rsp_valid/rsp_ready): exactly one item per request with
//   status, the granted address (0 unless granted) and the free count.
//   cfg channel (cfg_valid/cfg_ready): index 0 element_size, 1 pool_count;
//   always ready. Write only while the block is idle; initialize reloads
//   the stack with the new element_size, a new pool_count limits frees at once.
// Timing: an accepted item passes through the read stage and the output
//   register to rsp. The block takes one item per cycle while rsp is not stalled;
//   the stack RAM (one write, one registered read per cycle) sets that figure.
//   Initialize needs no loading pass: a fill mark records the lowest level
//   reached since the last initialize, and entries below it read as index * element_size from a multiplier.
// Reset: no clearing pass; the stack reads as if loaded with i * 64 and the
//   level is 1024 (limited to the stack depth).
// Stall: a stalled rsp holds the output register; one more item may wait in
//   the read stage, after which req_ready drops until rsp drains.
// ----------------------------------------------------------------------------
module free_list_buffer_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [flb_pkg::CMD_W-1:0]         command,
	input  logic [flb_pkg::ADDR_W-1:0]        elem_offset,
	input  logic                              elem_present,
	// response channel
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [flb_pkg::STATUS_W-1:0]      status,
	output logic [flb_pkg::ADDR_W-1:0]        address,
	output logic [flb_pkg::COUNT_W-1:0]       free_count,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [flb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [flb_pkg::CFG_DAT_W-1:0]     cfg_data
);

	localparam int ADDR_W  = flb_pkg::ADDR_W;
	localparam int SIZE_W  = flb_pkg::SIZE_W;
	localparam int COUNT_W = flb_pkg::COUNT_W;
	localparam int IDX_W   = flb_pkg::IDX_W;
	localparam int PROD_W  = IDX_W + SIZE_W;

	// Configuration registers
	logic [SIZE_W-1:0]  element_size_q;
	logic [COUNT_W-1:0] pool_count_q;

	// Stack state
	logic [COUNT_W-1:0] level_q;
	logic [COUNT_W-1:0] fill_mark_q;   // entries below this still hold their fill value
	logic [SIZE_W-1:0]  fill_size_q;   // element size captured at the last initialize

	// Read stage
	logic                   s1_valid_q;
	flb_pkg::status_t       status_s1;
	logic [COUNT_W-1:0]     count_s1;
	logic                   mem_sel_s1;
	logic [ADDR_W-1:0]      fill_s1;

	// Output register
	logic                   rsp_valid_q;
	flb_pkg::status_t       status_q;
	logic [ADDR_W-1:0]      address_q;
	logic [COUNT_W-1:0]     count_q;

	// Request decode
	logic                   req_fire;
	logic                   s1_adv;
	logic [COUNT_W-1:0]     eff_count;
	logic [COUNT_W-1:0]     level_dec;
	logic [IDX_W-1:0]       pop_idx;
	logic [IDX_W-1:0]       push_idx;
	logic                   from_fill;
	logic [PROD_W-1:0]      fill_prod;
	flb_pkg::status_t       status_d;
	logic [COUNT_W-1:0]     level_d;
	logic [COUNT_W-1:0]     fill_mark_d;
	logic [SIZE_W-1:0]      fill_size_d;
	logic                   ram_we;
	logic                   ram_re;
	logic                   mem_sel_d;
	logic [ADDR_W-1:0]      ram_rdata;

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign s1_adv    = !rsp_valid_q || rsp_ready;
	assign req_ready = !s1_valid_q || s1_adv;
	assign req_fire  = req_valid && req_ready;

	// Effective pool count: saturate at the stack depth.
	assign eff_count = (pool_count_q > COUNT_W'(flb_pkg::POOL_DEPTH)) ?
		COUNT_W'(flb_pkg::POOL_DEPTH) : pool_count_q;

	assign level_dec = level_q - COUNT_W'(1);
	assign pop_idx   = IDX_W'(level_dec);
	assign push_idx  = IDX_W'(level_q);
	// Top entry untouched since initialize when the level never dipped below it.
	assign from_fill = (level_q <= fill_mark_q);
	assign fill_prod = PROD_W'(pop_idx) * PROD_W'(fill_size_q);

	// ------------------------------------------------------------------
	// Command decode and next stack state
	// ------------------------------------------------------------------
	always_comb begin
		status_d    = flb_pkg::ST_INIT;
		level_d     = level_q;
		fill_mark_d = fill_mark_q;
		fill_size_d = fill_size_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		mem_sel_d   = 1'b0;
		unique case (command)
			flb_pkg::CMD_INIT, flb_pkg::CMD_INIT_ALT: begin
				status_d    = flb_pkg::ST_INIT;
				level_d     = eff_count;
				fill_mark_d = eff_count;
				fill_size_d = element_size_q;
			end
			flb_pkg::CMD_ALLOC: begin
				if (level_q == '0) begin
					status_d = flb_pkg::ST_EMPTY;
				end else begin
					status_d  = flb_pkg::ST_GRANTED;
					level_d   = level_dec;
					ram_re    = req_fire;
					mem_sel_d = !from_fill;
					if (from_fill) begin
						fill_mark_d = level_dec;
					end
				end
			end
			flb_pkg::CMD_FREE: begin
				priority if (!elem_present) begin
					status_d = flb_pkg::ST_NULL;
				end else if (level_q >= eff_count) begin
					status_d = flb_pkg::ST_FULL;
				end else begin
					status_d = flb_pkg::ST_FREED;
					level_d  = level_q + COUNT_W'(1);
					ram_we   = req_fire;
				end
			end
			default: begin
				status_d = flb_pkg::ST_INIT;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Stack memory
	// ------------------------------------------------------------------
	flb_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (flb_pkg::POOL_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (push_idx),
		.wdata (elem_offset),
		.re    (ram_re),
		.raddr (pop_idx),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Configuration and stack state registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_size_q <= SIZE_W'(flb_pkg::RESET_ELEMENT_SIZE);
			pool_count_q   <= COUNT_W'(flb_pkg::RESET_POOL_COUNT);
			level_q        <= COUNT_W'(flb_pkg::RESET_LEVEL);
			fill_mark_q    <= COUNT_W'(flb_pkg::RESET_LEVEL);
			fill_size_q    <= SIZE_W'(flb_pkg::RESET_ELEMENT_SIZE);
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					flb_pkg::REG_ELEMENT_SIZE: element_size_q <= cfg_data;
					flb_pkg::REG_POOL_COUNT:   pool_count_q   <= COUNT_W'(cfg_data);
					default: ;
				endcase
			end
			// Advance the stack on every accepted item.
			if (req_fire) begin
				level_q     <= level_d;
				fill_mark_q <= fill_mark_d;
				fill_size_q <= fill_size_d;
			end
		end
	end

	// ------------------------------------------------------------------
	// Read stage: wait for the RAM word, hold while the output is stalled
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_ready) begin
			s1_valid_q <= req_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			status_s1  <= status_d;
			count_s1   <= level_d;
			mem_sel_s1 <= mem_sel_d;
			fill_s1    <= ADDR_W'(fill_prod);
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			status_q <= status_s1;
			count_q  <= count_s1;
			// Pick the stored word or the fill value; drop both unless granted.
			if (status_s1 == flb_pkg::ST_GRANTED) begin
				address_q <= mem_sel_s1 ? ram_rdata : fill_s1;
			end else begin
				address_q <= '0;
			end
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign address    = address_q;
	assign free_count = count_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_push_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (level_q < eff_count))
		else $error("push at or above the pool count");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (level_q != '0) && !ram_we)
		else $error("pop from an empty stack or pop with push");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> s1_valid_q && $stable(status_s1) && $stable(count_s1))
		else $error("read stage lost its item under stall");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (level_q <= COUNT_W'(flb_pkg::POOL_DEPTH)) && s1_valid_q)
		else $error("stack level beyond depth or item dropped");

endmodule

// ===== rtl/flb_ram.sv =====
// ----------------------------------------------------------------------------
// flb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module flb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// Hold the last read word while no read is issued.
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the free-list buffer allocator. Requests go
// in over a valid/ready channel with random gaps. Each accepted request runs
// through a local model of the free-offset stack, which queues the response
// it should produce. Each response taken from the block is compared field by
// field against the oldest queued response. Directed tests cover the reset
// pool, an empty pool, the register extremes and a count lowered below the
// level. Long random phases follow, and one stretch backs up the response
// side until the request side stalls.
// ----------------------------------------------------------------------------
module testbench;
	import flb_pkg::*;

	typedef struct {
		status_t             status;
		logic [ADDR_W-1:0]   address;
		logic [COUNT_W-1:0]  free_count;
	} pool_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	logic [CMD_W-1:0]      command;
	logic [ADDR_W-1:0]     elem_offset;
	logic                  elem_present;
	logic                  rsp_valid;
	logic                  rsp_ready;
	logic [STATUS_W-1:0]   status;
	logic [ADDR_W-1:0]     address;
	logic [COUNT_W-1:0]    free_count;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DAT_W-1:0]  cfg_data;

	free_list_buffer_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.command      (command),
		.elem_offset  (elem_offset),
		.elem_present (elem_present),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.address      (address),
		.free_count   (free_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Local copy of the pool: the stack of free offsets, its level and the
	// two register values as the block should hold them.
	logic [ADDR_W-1:0]   free_offsets [POOL_DEPTH];
	int unsigned         level_model;
	logic [SIZE_W-1:0]   size_setting;
	logic [COUNT_W-1:0]  count_setting;

	// Responses owed by the block, oldest first.
	pool_reply_t         expected_replies [$];
	pool_reply_t         expected_item;
	// Offsets handed out and not yet returned; random frees draw from here.
	logic [ADDR_W-1:0]   held_offsets [$];

	int unsigned         failures;
	bit                  sender_gaps_on;
	bit                  receiver_stalls_on;
	int unsigned         drain_hold;
	int unsigned         stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run.
	initial begin
		#(10_000_000);
		$display("free_list_buffer_allocator regression: fail");
		$finish;
	end

	// Mostly short pauses, now and then a long one.
	function automatic int unsigned random_pause();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The block clips the register value at the stack depth.
	function automatic int unsigned usable_count();
		return (count_setting > POOL_DEPTH) ? POOL_DEPTH : count_setting;
	endfunction

	// Entry i holds i * element_size, wrapped to the offset width.
	function automatic void load_offsets();
		for (int i = 0; i < POOL_DEPTH; i++)
			free_offsets[i] = ADDR_W'(longint'(i) * longint'(size_setting));
	endfunction

	// Advance the pool model by one request and queue the response it owes.
	function automatic void predict_pool_step(input logic [CMD_W-1:0] cmd,
			input logic [ADDR_W-1:0] offset, input logic present);
		pool_reply_t reply;
		int unsigned limit;
		limit = usable_count();
		reply.address = '0;
		if (cmd[1]) begin
			// Both upper-bit commands reload the whole stack.
			load_offsets();
			level_model = limit;
			reply.status = ST_INIT;
			held_offsets.delete();
		end else if (cmd == CMD_ALLOC) begin
			if (level_model == 0) begin
				reply.status = ST_EMPTY;
			end else begin
				level_model--;
				reply.address = free_offsets[level_model];
				reply.status = ST_GRANTED;
				held_offsets.push_back(reply.address);
			end
		end else if (!present) begin
			// A null handle wins over the full check.
			reply.status = ST_NULL;
		end else if (level_model >= limit) begin
			reply.status = ST_FULL;
		end else begin
			free_offsets[level_model] = offset;
			level_model++;
			reply.status = ST_FREED;
		end
		reply.free_count = COUNT_W'(level_model);
		expected_replies.push_back(reply);
	endfunction

	// Offer one item and hold it until taken; valid stays up through a
	// zero-length gap so that back-to-back items need no extra edge.
	task automatic send_request(input logic [CMD_W-1:0] cmd,
			input logic [ADDR_W-1:0] offset, input logic present);
		command      <= cmd;
		elem_offset  <= offset;
		elem_present <= present;
		req_valid    <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_pool_step(cmd, offset, present);
		if (sender_gaps_on && $urandom_range(0, 99) < 40) begin
			req_valid <= 1'b0;
			repeat (random_pause()) @(posedge clk);
		end
	endtask

	// Drop valid, drain every owed response, then let the pipeline settle.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one or both registers while the block is idle.
	task automatic set_registers(input bit wr_size, input logic [CFG_DAT_W-1:0] size_data,
			input bit wr_count, input logic [CFG_DAT_W-1:0] count_data);
		wait_idle();
		if (wr_size) begin
			cfg_index <= REG_ELEMENT_SIZE;
			cfg_data  <= size_data;
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			size_setting = size_data;
		end
		if (wr_count) begin
			cfg_index <= REG_POOL_COUNT;
			cfg_data  <= count_data;
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			count_setting = count_data[COUNT_W-1:0];
		end
		cfg_valid <= 1'b0;
	endtask

	// Pool straight out of reset: full at the depth, spaced by 64 bytes.
	// Also hits the null handle on a full stack.
	task automatic test_reset_pool();
		send_request(CMD_ALLOC, '0, 1'b0);
		send_request(CMD_FREE, '1, 1'b1);
		send_request(CMD_FREE, '0, 1'b1);
		send_request(CMD_FREE, '1, 1'b0);
	endtask

	// Zero buffers: allocate is always empty, frees with a handle are full, a null free is null.
	// Then zero element size with a few buffers: every offset is zero.
	task automatic test_empty_pool();
		set_registers(1'b1, 16'd0, 1'b1, 16'd0);
		send_request(CMD_INIT, '0, 1'b0);
		send_request(CMD_ALLOC, '1, 1'b1);
		send_request(CMD_FREE, 26'h2AA_AAAA, 1'b1);
		send_request(CMD_FREE, 26'h155_5555, 1'b0);
		set_registers(1'b0, 16'd0, 1'b1, 16'd3);
		send_request(CMD_INIT, '0, 1'b0);
		send_request(CMD_ALLOC, '0, 1'b0);
	endtask

	// Largest element size with a count beyond the depth, then a pool of one.
	task automatic test_register_extremes();
		set_registers(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
		send_request(CMD_INIT_ALT, '0, 1'b0);
		send_request(CMD_ALLOC, '0, 1'b0);
		set_registers(1'b1, 16'd1, 1'b1, 16'd1);
		send_request(CMD_INIT, '0, 1'b0);
		send_request(CMD_ALLOC, '0, 1'b0);
		send_request(CMD_ALLOC, '0, 1'b0);
		send_request(CMD_FREE, 26'h000_0123, 1'b1);
	endtask

	// Lower the count under the current level without reloading: frees are
	// refused until allocations bring the level below the new count.
	task automatic test_count_lowered();
		set_registers(1'b1, 16'd48, 1'b1, 16'd8);
		send_request(CMD_INIT, '0, 1'b0);
		send_request(CMD_ALLOC, '0, 1'b0);
		send_request(CMD_ALLOC, '0, 1'b0);
		set_registers(1'b0, 16'd0, 1'b1, 16'd3);
		send_request(CMD_FREE, 26'h000_0040, 1'b1);
		repeat (4) send_request(CMD_ALLOC, '0, 1'b0);
		send_request(CMD_FREE, 26'h000_0040, 1'b1);
		send_request(CMD_FREE, 26'h000_0080, 1'b1);
	endtask

	// Hold responses off long enough that the block fills and stops taking
	// requests, while the sender keeps offering back to back.
	task automatic test_backpressure();
		set_registers(1'b1, 16'd8, 1'b1, 16'd64);
		send_request(CMD_INIT, '0, 1'b0);
		sender_gaps_on = 1'b0;
		drain_hold = 300;
		for (int i = 0; i < 20; i++)
			send_request((i % 3 == 2) ? CMD_FREE : CMD_ALLOC, ADDR_W'($urandom), 1'b1);
		sender_gaps_on = 1'b1;
	endtask

	// One random request, leaning toward alloc or free by the burst bias.
	task automatic send_random_item(input bit alloc_bias);
		int unsigned        roll;
		int unsigned        slot;
		logic [ADDR_W-1:0]  offset;
		roll   = $urandom_range(0, 99);
		offset = ADDR_W'($urandom);
		if (roll < 3) begin
			send_request($urandom_range(0, 1) ? CMD_INIT : CMD_INIT_ALT, offset,
				1'($urandom));
		end else if (roll < 8) begin
			send_request(CMD_FREE, offset, 1'b0);
		end else if (($urandom_range(0, 99) < 80) == alloc_bias) begin
			send_request(CMD_ALLOC, offset, 1'($urandom));
		end else begin
			// Return a buffer that was handed out, most of the time.
			if (held_offsets.size() != 0 && $urandom_range(0, 3) != 0) begin
				slot   = $urandom_range(0, held_offsets.size() - 1);
				offset = held_offsets[slot];
				held_offsets.delete(slot);
			end
			send_request(CMD_FREE, offset, 1'b1);
		end
	endtask

	// Phases of random traffic, each under a fresh register setting.
	task automatic test_random_traffic();
		logic [CFG_DAT_W-1:0]  size_data;
		logic [CFG_DAT_W-1:0]  count_data;
		int unsigned           burst_left;
		bit                    alloc_bias;
		for (int phase = 0; phase < 14; phase++) begin
			case ($urandom_range(0, 4))
				0:       size_data = 16'd1;
				1:       size_data = 16'hFFFF;
				2:       size_data = 16'd64;
				default: size_data = 16'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0:       count_data = 16'd1;
				1:       count_data = 16'd1024;
				2:       count_data = 16'd0;
				3:       count_data = 16'hFFFF;
				default: count_data = {5'($urandom), 11'($urandom_range(2, 40))};
			endcase
			set_registers($urandom_range(0, 3) != 0, size_data,
				$urandom_range(0, 3) != 0, count_data);
			// Mostly reload; sometimes run on with the old stack contents.
			if ($urandom_range(0, 3) != 0)
				send_request(CMD_INIT, '0, 1'b0);
			sender_gaps_on     = $urandom_range(0, 3) != 0;
			receiver_stalls_on = $urandom_range(0, 3) != 0;
			burst_left = 0;
			alloc_bias = 1'b1;
			for (int n = 0; n < 100; n++) begin
				if (burst_left == 0) begin
					alloc_bias = 1'($urandom);
					burst_left = $urandom_range(4, 24);
				end
				burst_left--;
				send_random_item(alloc_bias);
			end
		end
		sender_gaps_on     = 1'b1;
		receiver_stalls_on = 1'b1;
	endtask

	// Response side: ready with random stalls, or held off on request.
	initial begin
		rsp_ready  <= 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (drain_hold != 0) begin
				drain_hold--;
				rsp_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (receiver_stalls_on && $urandom_range(0, 99) < 30) begin
				stall_left = random_pause() - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Compare each response taken against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: response with none owed: status %0d address %0h count %0d",
					$time, status, address, free_count);
				failures++;
			end else begin
				expected_item = expected_replies.pop_front();
				if (status !== expected_item.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, expected_item.status, status);
					failures++;
				end
				if (address !== expected_item.address) begin
					$display("%0t: address expected %0h actual %0h",
						$time, expected_item.address, address);
					failures++;
				end
				if (free_count !== expected_item.free_count) begin
					$display("%0t: free_count expected %0d actual %0d",
						$time, expected_item.free_count, free_count);
					failures++;
				end
			end
		end
	end

	initial begin
		failures           = 0;
		drain_hold         = 0;
		sender_gaps_on     = 1'b1;
		receiver_stalls_on = 1'b1;
		size_setting       = SIZE_W'(RESET_ELEMENT_SIZE);
		count_setting      = COUNT_W'(RESET_POOL_COUNT);
		level_model        = RESET_LEVEL;
		load_offsets();
		arst_n       <= 1'b0;
		req_valid    <= 1'b0;
		command      <= CMD_ALLOC;
		elem_offset  <= '0;
		elem_present <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_ELEMENT_SIZE;
		cfg_data     <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_pool();
		test_empty_pool();
		test_register_extremes();
		test_count_lowered();
		test_backpressure();
		test_random_traffic();

		// Drain, then give any stray response time to show up.
		wait_idle();
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("free_list_buffer_allocator regression: pass");
		else
			$display("free_list_buffer_allocator regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/flb_pkg.sv
rtl/flb_ram.sv
rtl/free_list_buffer_allocator.sv
dv/testbench.sv
